/* src/assert_macros.svh */
// assertion helpers for the liveness table checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define HBT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("hbt assertion failed");

// condition must never be seen outside reset
`define HBT_ASSERT_NEVER(label, clk, rst_n, cond) \
  `HBT_ASSERT(label, clk, rst_n, !(cond))

`endif

/* src/hbt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package hbt_pkg;

  localparam int NUM_SLOTS   = 16;
  localparam int IDX_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int MAX_RESULTS = 16;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W      = 3;

  localparam logic [31:0] TIMEOUT_RESET = 32'd15000;

  typedef enum logic {
    OP_HEARTBEAT = 1'b0,
    OP_CHECK     = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    EV_REGISTERED  = 3'd0,
    EV_RECONNECTED = 3'd1,
    EV_REFRESHED   = 3'd2,
    EV_FULL        = 3'd3,
    EV_LOST        = 3'd4
  } event_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_HB_SCAN,
    B_HB_DONE,
    B_CHK_SCAN,
    B_CHK_DONE
  } back_state_e;

  typedef struct packed {
    logic        operation;
    logic [31:0] node_address;
    logic [15:0] room_tag;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [3:0]  slot;
    logic [31:0] node_address_res;
    logic [15:0] room_tag_res;
    logic        last;
  } out_item_t;

  typedef struct packed {
    op_e         op;
    logic [31:0] node_address;
    logic [15:0] room_tag;
    logic [31:0] now_ms;
  } cmd_t;

endpackage
`default_nettype wire

/* src/hbt_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module hbt_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  hbt_pkg::in_item_t item_i,
  output hbt_pkg::cmd_t    cmd_o,
  output logic             cmd_valid_o,
  input  logic             cmd_pop_i
);
  import hbt_pkg::*;

  cmd_t              q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;
  cmd_t              cmd_in;

  // classify the incoming word
  always_comb begin
    cmd_in.op           = item_i.operation ? OP_CHECK : OP_HEARTBEAT;
    cmd_in.node_address = item_i.node_address;
    cmd_in.room_tag     = item_i.room_tag;
    cmd_in.now_ms       = item_i.now_ms;
  end

  assign busy_o      = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rd_ptr_q];
  assign push        = start_i && !busy_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_q + 1'b1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_q + 1'b1);
    end
    if (push && !pop) begin
      cnt_d = QCNT_W'(cnt_q + 1'b1);
    end else if (pop && !push) begin
      cnt_d = QCNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

endmodule
`default_nettype wire

/* src/hbt_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module hbt_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hbt_pkg::cmd_t     cmd_i,
  input  logic              cmd_valid_i,
  output logic              cmd_pop_o,
  input  logic [31:0]       timeout_ms_i,
  output logic              result_strobe_o,
  output hbt_pkg::out_item_t result_o
);
  import hbt_pkg::*;

  back_state_e state_q, state_d;

  // slot table
  logic        used_q   [NUM_SLOTS];
  logic        online_q [NUM_SLOTS];
  logic [31:0] addr_mem [NUM_SLOTS];
  logic [15:0] room_mem [NUM_SLOTS];
  logic [31:0] seen_mem [NUM_SLOTS];

  cmd_t                 cmd_q;
  logic [IDX_W-1:0]     idx_q;
  logic                 hit_found_q, free_found_q;
  logic [IDX_W-1:0]     hit_idx_q, free_idx_q;
  logic                 pend_valid_q;
  out_item_t            pend_q;
  logic [RES_CNT_W-1:0] res_cnt_q;
  logic                 strobe_q;
  out_item_t            res_q;

  logic        last_idx;
  logic        rd_used, rd_online, rd_hit, rd_lost;
  logic [31:0] rd_age;

  // result and slot-write controls
  logic             emit;
  out_item_t        emit_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic             wr_new;
  event_e           hb_ev;

  assign last_idx  = (idx_q == IDX_W'(NUM_SLOTS - 1));
  assign rd_used   = used_q[idx_q];
  assign rd_online = online_q[idx_q];
  assign rd_age    = cmd_q.now_ms - seen_mem[idx_q];
  assign rd_hit    = rd_used && (addr_mem[idx_q] == cmd_q.node_address);
  assign rd_lost   = rd_used && rd_online && (rd_age > timeout_ms_i)
                     && (res_cnt_q < RES_CNT_W'(MAX_RESULTS));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          state_d = (cmd_i.op == OP_CHECK) ? B_CHK_SCAN : B_HB_SCAN;
        end
      end
      B_HB_SCAN: begin
        if (last_idx) state_d = B_HB_DONE;
      end
      B_CHK_SCAN: begin
        if (last_idx) state_d = B_CHK_DONE;
      end
      B_HB_DONE:  state_d = B_IDLE;
      B_CHK_DONE: state_d = B_IDLE;
      default:    state_d = B_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o = 1'b0;
    emit      = 1'b0;
    emit_data = pend_q;
    wr_en     = 1'b0;
    wr_idx    = hit_idx_q;
    wr_new    = 1'b0;
    hb_ev     = EV_FULL;
    unique case (state_q)
      B_IDLE: cmd_pop_o = cmd_valid_i;
      B_HB_DONE: begin
        emit = 1'b1;
        if (hit_found_q) begin
          hb_ev  = online_q[hit_idx_q] ? EV_REFRESHED : EV_RECONNECTED;
          wr_en  = 1'b1;
          wr_idx = hit_idx_q;
        end else if (free_found_q) begin
          hb_ev  = EV_REGISTERED;
          wr_en  = 1'b1;
          wr_idx = free_idx_q;
          wr_new = 1'b1;
        end
        emit_data.event_res        = hb_ev;
        // table full reports slot zero
        emit_data.slot             = wr_en ? 4'(wr_idx) : 4'd0;
        emit_data.node_address_res = cmd_q.node_address;
        emit_data.room_tag_res     = cmd_q.room_tag;
        emit_data.last             = 1'b1;
      end
      B_CHK_SCAN: begin
        // a held loss goes out once a later one shows it was not the final one
        emit           = rd_lost && pend_valid_q;
        emit_data.last = 1'b0;
      end
      B_CHK_DONE: begin
        emit           = pend_valid_q;
        emit_data.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_IDLE;
      idx_q        <= '0;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      pend_valid_q <= 1'b0;
      res_cnt_q    <= '0;
      strobe_q     <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        used_q[i]   <= 1'b0;
        online_q[i] <= 1'b0;
      end
    end else begin
      state_q  <= state_d;
      strobe_q <= emit;
      if (cmd_pop_o) begin
        idx_q        <= '0;
        hit_found_q  <= 1'b0;
        free_found_q <= 1'b0;
        pend_valid_q <= 1'b0;
        res_cnt_q    <= '0;
      end
      if (state_q == B_HB_SCAN) begin
        idx_q <= IDX_W'(idx_q + 1'b1);
        if (rd_hit && !hit_found_q) hit_found_q <= 1'b1;
        if (!rd_used && !free_found_q) free_found_q <= 1'b1;
      end
      if (state_q == B_CHK_SCAN) begin
        idx_q <= IDX_W'(idx_q + 1'b1);
        if (rd_lost) begin
          online_q[idx_q] <= 1'b0;
          pend_valid_q    <= 1'b1;
          res_cnt_q       <= RES_CNT_W'(res_cnt_q + 1'b1);
        end
      end
      if (wr_en) begin
        online_q[wr_idx] <= 1'b1;
        if (wr_new) used_q[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) cmd_q <= cmd_i;
    if (state_q == B_HB_SCAN) begin
      if (rd_hit && !hit_found_q) hit_idx_q <= idx_q;
      if (!rd_used && !free_found_q) free_idx_q <= idx_q;
    end
    if (state_q == B_CHK_SCAN && rd_lost) begin
      pend_q.event_res        <= EV_LOST;
      pend_q.slot             <= 4'(idx_q);
      pend_q.node_address_res <= addr_mem[idx_q];
      pend_q.room_tag_res     <= room_mem[idx_q];
      pend_q.last             <= 1'b0;
    end
    if (emit) res_q <= emit_data;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      addr_mem[wr_idx] <= cmd_q.node_address;
      room_mem[wr_idx] <= cmd_q.room_tag;
      seen_mem[wr_idx] <= cmd_q.now_ms;
    end
  end

  assign result_strobe_o = strobe_q;
  assign result_o        = res_q;

endmodule
`default_nettype wire

/* src/heartbeat_table_with_timeout_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Liveness table of 16 node slots. A word is taken when start is high and busy is low; a
// two-entry command queue sits in front of the slot engine, so busy rises only when two
// words wait. Every word, heartbeat or check, takes the engine through the same steps: it
// fetches the command, walks the table a slot per cycle, then finishes the word. A
// heartbeat gives one result; a check gives one result per node found lost, at most one
// per cycle, and none when nothing aged out. Results appear on result_o for exactly one
// cycle with result_strobe_o high and cannot be stalled, so the receiver must take every
// result as it comes. timeout_ms sits at byte address 0 of the register port and must only
// be written while the table is idle.
module heartbeat_table_with_timeout_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  hbt_pkg::in_item_t          item_i,
  output logic                       result_strobe_o,
  output hbt_pkg::out_item_t         result_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hbt_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import hbt_pkg::*;

  localparam logic REG_TIMEOUT = 1'b0;

  logic [31:0] timeout_q;
  logic        cfg_wr;
  cmd_t        cmd;
  logic        cmd_valid;
  logic        cmd_pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TIMEOUT);
  assign prdata = (paddr[2] == REG_TIMEOUT) ? timeout_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_wr) begin
      timeout_q <= pwdata;
    end
  end

  hbt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .item_i      (item_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  hbt_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cmd_valid_i     (cmd_valid),
    .cmd_pop_o       (cmd_pop),
    .timeout_ms_i    (timeout_q),
    .result_strobe_o (result_strobe_o),
    .result_o        (result_o)
  );

endmodule
`default_nettype wire

/* src/hbt_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module hbt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               result_strobe_o,
  input hbt_pkg::out_item_t result_o,
  input logic               pready
);
  import hbt_pkg::*;

  logic res_bad, res_hb, res_full, res_last;

  assign res_bad  = result_strobe_o && (result_o.event_res > EV_LOST);
  assign res_hb   = result_strobe_o && (result_o.event_res != EV_LOST);
  assign res_full = result_strobe_o && (result_o.event_res == EV_FULL);
  assign res_last = result_strobe_o && result_o.last;

  // register port never waits
  `HBT_ASSERT(a_pready_high, clk_i, rst_ni, pready)
  // no event code beyond node lost
  `HBT_ASSERT_NEVER(a_event_range, clk_i, rst_ni, res_bad)
  // a heartbeat answer is always the only result of its word
  `HBT_ASSERT(a_hb_last, clk_i, rst_ni, res_hb |-> result_o.last)
  // table full names slot zero
  `HBT_ASSERT(a_full_slot, clk_i, rst_ni, res_full |-> (result_o.slot == 4'd0))
  // the engine goes idle after the final result of a word, so a quiet cycle follows it
  `HBT_ASSERT(a_gap_after_last, clk_i, rst_ni, res_last |=> !result_strobe_o)

endmodule

bind heartbeat_table_with_timeout_top hbt_checker u_hbt_checker (.*);
`default_nettype wire
